[sv/fspc_pkg.sv]
// Shared types and constants for the framed sample pulse counter.
package fspc_pkg;

  // Frame layout: three header bytes, high byte, low byte, check byte
  localparam int unsigned FRAME_BYTES = 6;

  localparam logic [7:0] HDR0 = 8'h23;  // '#'
  localparam logic [7:0] HDR1 = 8'h24;  // '$'
  localparam logic [7:0] HDR2 = 8'h3A;  // ':'

  // Input mode codes
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_CLEAR    = 2'd1;
  localparam logic [1:0] MODE_EDGE_RST = 2'd2;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_LIMIT  = 1'b0;
  localparam logic        REG_GAIN   = 1'b1;
  localparam logic [9:0]  LIMIT_RST  = 10'd20;
  localparam logic [3:0]  GAIN_RST   = 4'd5;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Command queue depth (power of two so pointers wrap)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Deframer position
  typedef enum logic [2:0] {
    FP_HUNT  = 3'd0,
    FP_HDR1  = 3'd1,
    FP_HDR2  = 3'd2,
    FP_HIGH  = 3'd3,
    FP_LOW   = 3'd4,
    FP_CHECK = 3'(FRAME_BYTES - 1)
  } pos_t;

  // Work handed from the deframer to the sample unit
  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_EDGE_RST = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] raw;
  } cmd_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    cmd_t data;
  } q_push_t;

  typedef struct packed {
    logic full;
  } q_wstat_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_rstat_t;

  typedef struct packed {
    logic [9:0] limit;
    logic [3:0] gain;
  } cfg_t;

endpackage

[sv/fspc_in_if.sv]
// Input byte/command channel interface.
interface fspc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, mode, data_byte, input ready);
  modport sink (input valid, mode, data_byte, output ready);
endinterface

[sv/fspc_out_if.sv]
// Result channel interface.
interface fspc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_value;
  logic [13:0] sample_value;
  logic        pulse_seen;
  logic [15:0] pulse_count;

  modport source (output valid, raw_value, sample_value, pulse_seen, pulse_count,
                  input ready);
  modport sink (input valid, raw_value, sample_value, pulse_seen, pulse_count,
                output ready);
endinterface

[sv/fspc_front.sv]
// Deframer: accepts input transfers, hunts headers, checks frames, issues commands.
module fspc_front
  import fspc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fspc_in_if.sink       in_ch,
  input  q_wstat_t      q_wstat,
  output q_push_t       q_push
);

  pos_t        pos_r, pos_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = ~q_wstat.full;
  assign accept      = in_ch.valid & ~q_wstat.full;
  assign b           = in_ch.data_byte;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= FP_HUNT;
      xor_r <= '0;
      hi_r  <= '0;
      lo_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
    end
  end

  // Next position, running check and command issue
  always_comb begin
    pos_nxt        = pos_r;
    xor_nxt        = xor_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    q_push.push    = 1'b0;
    q_push.data.kind = CMD_SAMPLE;
    q_push.data.raw  = {hi_r, lo_r};

    if (accept) begin
      unique case (in_ch.mode)
        MODE_CLEAR: begin
          q_push.push      = 1'b1;
          q_push.data.kind = CMD_CLEAR;
        end
        MODE_EDGE_RST: begin
          q_push.push      = 1'b1;
          q_push.data.kind = CMD_EDGE_RST;
        end
        MODE_BYTE: begin
          unique case (pos_r)
            FP_HDR1: begin
              if (b == HDR1) begin
                xor_nxt = xor_r ^ b;
                pos_nxt = FP_HDR2;
              end else begin
                pos_nxt = (b == HDR0) ? FP_HDR1 : FP_HUNT;
                xor_nxt = (b == HDR0) ? b : 8'h00;
              end
            end
            FP_HDR2: begin
              if (b == HDR2) begin
                xor_nxt = xor_r ^ b;
                pos_nxt = FP_HIGH;
              end else begin
                pos_nxt = (b == HDR0) ? FP_HDR1 : FP_HUNT;
                xor_nxt = (b == HDR0) ? b : 8'h00;
              end
            end
            FP_HIGH: begin
              hi_nxt  = b;
              xor_nxt = xor_r ^ b;
              pos_nxt = FP_LOW;
            end
            FP_LOW: begin
              lo_nxt  = b;
              xor_nxt = xor_r ^ b;
              pos_nxt = FP_CHECK;
            end
            FP_CHECK: begin
              // frame is consumed whether or not the check matches
              pos_nxt     = FP_HUNT;
              xor_nxt     = 8'h00;
              q_push.push = (xor_r == b);
            end
            default: begin
              // hunting: a '#' opens a header
              pos_nxt = (b == HDR0) ? FP_HDR1 : FP_HUNT;
              xor_nxt = (b == HDR0) ? b : 8'h00;
            end
          endcase
        end
        default: ;  // unused mode: ignored
      endcase
    end
  end

endmodule

[sv/fspc_queue.sv]
// Short command queue between the deframer and the sample unit.
module fspc_queue
  import fspc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  q_push,
  input  logic     pop,
  output q_wstat_t q_wstat,
  output q_rstat_t q_rstat
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign q_wstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_rstat.empty = (count_r == '0);
  assign q_rstat.head  = mem_r[rd_ptr_r];

  assign do_push = q_push.push & ~q_wstat.full;
  assign do_pop  = pop & ~q_rstat.empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_push.data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[sv/fspc_back.sv]
// Sample unit: limits and scales samples, detects rising edges, counts pulses.
module fspc_back
  import fspc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  q_rstat_t q_rstat,
  output logic     pop,
  fspc_out_if.source out_ch
);

  logic [13:0] prev_r;
  logic        rising_r;
  logic [15:0] total_r;
  logic        out_valid_r;
  logic [15:0] out_raw_r;
  logic [13:0] out_sample_r;
  logic        out_seen_r;
  logic [15:0] out_count_r;

  cmd_t        cmd;
  logic        out_free;
  logic        over;
  logic [13:0] sample;
  logic        not_below;
  logic        seen;
  logic [15:0] total_inc;

  assign cmd      = q_rstat.head;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign pop      = ~q_rstat.empty & ((cmd.kind != CMD_SAMPLE) | out_free);

  // Limit and scale: within the limit raw fits in 10 bits
  assign over      = (cmd.raw > {6'd0, cfg.limit});
  assign sample    = over ? 14'd0 : (14'(cmd.raw[9:0]) * 14'(cfg.gain));
  assign not_below = (prev_r <= sample);
  assign seen      = not_below & ~rising_r;
  assign total_inc = (total_r == COUNT_MAX) ? total_r : total_r + 16'd1;

  // Edge detector and pulse count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      rising_r <= 1'b0;
      total_r  <= '0;
    end else if (pop) begin
      case (cmd.kind)
        CMD_CLEAR: total_r <= '0;
        CMD_EDGE_RST: begin
          prev_r   <= '0;
          rising_r <= 1'b0;
        end
        default: begin
          prev_r   <= sample;
          rising_r <= not_below;
          if (seen) total_r <= total_inc;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pop & (cmd.kind == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_raw_r    <= cmd.raw;
      out_sample_r <= sample;
      out_seen_r   <= seen;
      out_count_r  <= seen ? total_inc : total_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.raw_value    = out_raw_r;
  assign out_ch.sample_value = out_sample_r;
  assign out_ch.pulse_seen   = out_seen_r;
  assign out_ch.pulse_count  = out_count_r;

endmodule

[sv/framed_sample_pulse_counter_top.sv]
// Top level: configuration registers, deframer, command queue and sample unit.
//
// The block takes one input transfer per clock while in_ch.ready is high: a serial
// byte (mode 0), a pulse count clear (mode 1) or an edge detector reset (mode 2).
// The deframer hunts for the header '#','$',':', collects high byte, low byte and
// check byte, and for a frame whose XOR check matches it queues a sample command;
// clear and edge reset are queued in order with samples. A two-entry queue
// separates the deframer from the sample unit, which limits and scales the sample
// with a 10x4 multiply, tracks rising edges and keeps a saturating 16-bit pulse
// count. One item is taken every cycle unless the queue is full; a sample result
// passes through the queue into the output register that drives out_ch.valid, and
// a stalled result channel backs up through the queue to in_ch.ready. Registers:
// sample_limit at byte address 0 (reset 20), sample_gain at byte address 4 (reset 5).
module framed_sample_pulse_counter_top
  import fspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fspc_in_if.sink               in_ch,
  fspc_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [9:0] limit_r;
  logic [3:0] gain_r;
  logic       cfg_wr;
  logic       reg_sel;
  cfg_t       cfg;
  q_push_t    q_push;
  q_wstat_t   q_wstat;
  q_rstat_t   q_rstat;
  logic       pop;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_LIMIT: limit_r <= pwdata[9:0];
        REG_GAIN:  gain_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LIMIT: prdata = {22'd0, limit_r};
      REG_GAIN:  prdata = {28'd0, gain_r};
      default:   prdata = '0;
    endcase
  end

  assign cfg.limit = limit_r;
  assign cfg.gain  = gain_r;

  fspc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_wstat (q_wstat),
    .q_push  (q_push)
  );

  fspc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .pop     (pop),
    .q_wstat (q_wstat),
    .q_rstat (q_rstat)
  );

  fspc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_rstat (q_rstat),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/framed_sample_pulse_counter_top_test.sv]
// Self-checking testbench for the framed sample pulse counter top level.
module framed_sample_pulse_counter_top_test;
  import fspc_pkg::*;

  // Mode 3 has no package code; the block ignores it
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } stim_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [13:0] level;
    logic        seen;
    logic [15:0] count_after;
  } reading_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fspc_in_if  in_ch();
  fspc_out_if out_ch();

  framed_sample_pulse_counter_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Pending input items and expected frame readings
  stim_t    byte_feed[$];
  reading_t frames_due[$];
  stim_t    in_flight;

  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // Predictor state: deframer, edge detector, pulse counter, registers
  pos_t        at_pos;
  logic [7:0]  chk_acc;
  logic [7:0]  hi_byte;
  logic [7:0]  lo_byte;
  logic [13:0] last_level;
  logic        climbing;
  logic [15:0] pulses;
  logic [9:0]  cur_limit;
  logic [3:0]  cur_gain;

  // Go back to hunting; a '#' starts a fresh header right away
  task automatic hunt_from(input logic [7:0] b);
    if (b == HDR0) begin
      at_pos  = FP_HDR1;
      chk_acc = b;
    end else begin
      at_pos  = FP_HUNT;
      chk_acc = '0;
    end
  endtask

  // Advance the predictor by one accepted item; queue a reading per good frame
  task automatic deframe_and_count(input stim_t it);
    reading_t    r;
    logic [31:0] prod;
    case (it.mode)
      MODE_CLEAR: pulses = '0;
      MODE_EDGE_RST: begin
        last_level = '0;
        climbing   = 1'b0;
      end
      MODE_BYTE: begin
        case (at_pos)
          FP_HUNT: hunt_from(it.data);
          FP_HDR1: begin
            if (it.data == HDR1) begin
              chk_acc ^= it.data;
              at_pos = FP_HDR2;
            end else begin
              hunt_from(it.data);
            end
          end
          FP_HDR2: begin
            if (it.data == HDR2) begin
              chk_acc ^= it.data;
              at_pos = FP_HIGH;
            end else begin
              hunt_from(it.data);
            end
          end
          FP_HIGH: begin
            hi_byte = it.data;
            chk_acc ^= it.data;
            at_pos = FP_LOW;
          end
          FP_LOW: begin
            lo_byte = it.data;
            chk_acc ^= it.data;
            at_pos = FP_CHECK;
          end
          default: begin
            // check byte: frame consumed whether or not it matches
            at_pos = FP_HUNT;
            if (chk_acc == it.data) begin
              r.raw = {hi_byte, lo_byte};
              prod = 32'(r.raw) * 32'(cur_gain);
              r.level = (r.raw > 16'(cur_limit)) ? '0 : prod[13:0];
              r.seen = 1'b0;
              if (last_level <= r.level) begin
                if (!climbing) begin
                  r.seen = 1'b1;
                  if (pulses != COUNT_MAX) pulses++;
                end
                climbing = 1'b1;
              end else begin
                climbing = 1'b0;
              end
              last_level = r.level;
              r.count_after = pulses;
              frames_due.push_back(r);
            end
            chk_acc = '0;
          end
        endcase
      end
      default: ;
    endcase
  endtask

  // Input driver
  always @(posedge clk) begin
    stim_t nxt;
    logic  drive_v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_and_count(in_flight);
      drive_v = in_ch.valid && !in_ch.ready;
      if (!drive_v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_feed.size() != 0) begin
          nxt = byte_feed.pop_front();
          in_flight = nxt;
          in_ch.mode <= nxt.mode;
          in_ch.data_byte <= nxt.data;
          drive_v = 1'b1;
          if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
            gap_left = $urandom_range(1, 12);
        end
      end
      in_ch.valid <= drive_v;
    end
  end

  function automatic void match_field(string tag, int unsigned want, int unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
    end
  endfunction

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    reading_t want;
    logic     rdy;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (frames_due.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, expected none actual raw %0d sample %0d",
                   $time, out_ch.raw_value, out_ch.sample_value);
        end else begin
          want = frames_due.pop_front();
          match_field("raw_value", want.raw, out_ch.raw_value);
          match_field("sample_value", want.level, out_ch.sample_value);
          match_field("pulse_seen", want.seen, out_ch.pulse_seen);
          match_field("pulse_count", want.count_after, out_ch.pulse_count);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 11);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** framed_sample_pulse_counter_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic feed(input logic [1:0] mode, input logic [7:0] data);
    stim_t s;
    s.mode = mode;
    s.data = data;
    byte_feed.push_back(s);
  endtask

  // Full frame; a bad check flips at least one bit
  task automatic add_frame(input logic [15:0] raw, input bit good);
    logic [7:0] chk;
    chk = HDR0 ^ HDR1 ^ HDR2 ^ raw[15:8] ^ raw[7:0];
    if (!good) chk ^= 8'($urandom_range(1, 255));
    feed(MODE_BYTE, HDR0);
    feed(MODE_BYTE, HDR1);
    feed(MODE_BYTE, HDR2);
    feed(MODE_BYTE, raw[15:8]);
    feed(MODE_BYTE, raw[7:0]);
    feed(MODE_BYTE, chk);
  endtask

  // Raw values mostly inside the limit so samples move up and down
  function automatic logic [15:0] draw_raw();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, cur_limit));
      6, 7:             return 16'(cur_limit) + 16'($urandom_range(0, 3));
      8:                return 16'($urandom);
      default:          return '0;
    endcase
  endfunction

  // Mostly well-formed frames with random content, plus noise and broken headers
  task automatic queue_random_traffic(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_frame(draw_raw(), $urandom_range(0, 9) != 0);
        made += 6;
      end else if (pick < 80) begin
        feed(MODE_CLEAR, 8'($urandom));
        made++;
      end else if (pick < 85) begin
        feed(MODE_EDGE_RST, 8'($urandom));
        made++;
      end else if (pick < 88) begin
        feed(MODE_IGNORED, 8'($urandom));
      end else if (pick < 94) begin
        feed(MODE_BYTE, ($urandom_range(0, 9) == 0) ? HDR0 : 8'($urandom));
        made++;
      end else begin
        feed(MODE_BYTE, HDR0);
        if ($urandom_range(0, 1)) begin
          feed(MODE_BYTE, HDR1);
          made++;
        end
        feed(MODE_BYTE, ($urandom_range(0, 3) == 0) ? HDR0 : 8'($urandom));
        made += 2;
      end
    end
  endtask

  // Wait until every item is taken and every reading has come back
  task automatic drain();
    while (byte_feed.size() != 0 || in_ch.valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes it on the access edge
  task automatic set_register(input logic idx, input int unsigned v);
    logic [31:0] mask;
    mask = (idx == REG_LIMIT) ? 32'h3FF : 32'hF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(idx));
    pwdata  <= ($urandom & ~mask) | (v & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LIMIT) cur_limit = 10'(v);
    else cur_gain = 4'(v);
  endtask

  initial begin
    int unsigned lim;
    int unsigned gn;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_BYTE;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_idle_pct = 15;
    out_idle_pct = 15;
    at_pos = FP_HUNT;
    chk_acc = '0;
    hi_byte = '0;
    lo_byte = '0;
    last_level = '0;
    climbing = 1'b0;
    pulses = '0;
    cur_limit = LIMIT_RST;
    cur_gain = GAIN_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: limit edge, over-limit max raw, '#' restarts, bad check, modes
    add_frame(16'd20, 1'b1);
    feed(MODE_BYTE, HDR0);
    add_frame(16'hFFFF, 1'b1);
    feed(MODE_BYTE, HDR0);
    feed(MODE_BYTE, HDR1);
    add_frame(16'h0000, 1'b0);
    feed(MODE_IGNORED, HDR0);
    feed(MODE_CLEAR, 8'hFF);
    feed(MODE_EDGE_RST, 8'h00);
    drain();

    // Random phases over register extremes and random settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lim = 1023; gn = 15; end
        1: begin lim = 0;    gn = 0;  end
        2: begin lim = 1023; gn = 0;  end
        3: begin lim = 0;    gn = 15; end
        default: begin
          lim = $urandom_range(0, 1023);
          gn  = $urandom_range(0, 15);
        end
      endcase
      set_register(REG_LIMIT, lim);
      set_register(REG_GAIN, gn);
      in_idle_pct  = (p == 1) ? 0 : $urandom_range(5, 30);
      out_idle_pct = (p == 1) ? 0 : $urandom_range(5, 30);
      queue_random_traffic(225);
      drain();
    end

    // Closing stretch without idling
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_register(REG_LIMIT, $urandom_range(0, 1023));
    set_register(REG_GAIN, $urandom_range(0, 15));
    queue_random_traffic(150);
    drain();
    repeat (16) @(posedge clk);

    if (fault_count == 0) begin
      $display("** framed_sample_pulse_counter_top: PASSED **");
    end else begin
      $display("** framed_sample_pulse_counter_top: FAILED **");
    end
    $finish;
  end

endmodule
